// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

// ===== rtl/core/mdsa_pkg.sv =====
// ----------------------------------------------------------------------------
// mdsa_pkg
// Constants and calendar helpers for the monthly date step adder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mdsa_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int STEP_W   = 16;
    // month index: year * 12 + month - 1 + step, signed
    localparam int TOTAL_W  = 20;

    localparam int MONTHS_PER_YEAR = 12;
    localparam int ANCHOR_DAY      = 24;
    localparam int YEAR_MIN        = 1400;
    localparam int YEAR_MAX        = 9999;
    localparam int TOTAL_MIN       = YEAR_MIN * MONTHS_PER_YEAR;
    localparam int TOTAL_MAX       = YEAR_MAX * MONTHS_PER_YEAR + MONTHS_PER_YEAR - 1;

    // ceil(2^17 / 3): exact x / 3 for x below 2^15
    localparam int RECIP_3   = 43691;
    // ceil(2^19 / 100): exact x / 100 for x below 2^14
    localparam int RECIP_100 = 5243;

    localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

    // Gregorian leap year; century test via reciprocal multiply
    function automatic logic leap_year(input logic [YEAR_W-1:0] y);
        logic [26:0]       prod;
        logic [7:0]        cent;
        logic [YEAR_W-1:0] rem;
        prod = 27'(y) * 27'(RECIP_100);
        cent = prod[26:19];
        rem  = y - YEAR_W'(YEAR_W'(cent) * YEAR_W'(100));
        return (y[1:0] == 2'b00) && ((rem != '0) || (cent[1:0] == 2'b00));
    endfunction

    // Days in month m (1..12)
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] d;
        case (m) inside
            MON_FEB:                          d = leap ? 5'd29 : 5'd28;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: d = 5'd30;
            default:                          d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/core/monthly_date_step_add_core.sv =====
// ----------------------------------------------------------------------------
// monthly_date_step_add_core
// Throughput: one beat per cycle; two pipeline stages stall together when
// the result beat is not taken (s_ready = !m_valid || m_ready).
// Reset: synchronous active-low aresetn clears the stage valid bits only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module monthly_date_step_add_core
    import mdsa_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    // input channel
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [YEAR_W-1:0]         s_start_year,
    input  logic [MONTH_W-1:0]        s_start_month,
    input  logic [DAY_W-1:0]          s_start_day,
    input  logic signed [STEP_W-1:0]  s_months_to_add,
    // result channel
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [YEAR_W-1:0]         m_result_year,
    output logic [MONTH_W-1:0]        m_result_month,
    output logic [DAY_W-1:0]          m_result_day,
    output logic                      m_out_of_range
);

    // pipeline advance
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // ---------------- stage 1: month index, year/month split ----------------
    logic [MONTH_W-1:0]        mon_c;
    logic [17:0]               y12;
    logic signed [TOTAL_W-1:0] total;
    logic                      oor;
    logic [16:0]               t17;
    logic [30:0]               prod3;
    logic [YEAR_W-1:0]         ny;
    logic [16:0]               ny12;
    logic [16:0]               rem17;
    logic [MONTH_W-1:0]        nm;
    logic [DAY_W-1:0]          old_len;

    always_comb begin
        // clamp month to 1..12
        if (s_start_month < MON_JAN) begin
            mon_c = MON_JAN;
        end else if (s_start_month > MON_DEC) begin
            mon_c = MON_DEC;
        end else begin
            mon_c = s_start_month;
        end
        y12   = {1'b0, s_start_year, 3'b000} + {2'b00, s_start_year, 2'b00};
        total = $signed({2'b00, y12})
              + $signed({{(TOTAL_W-MONTH_W){1'b0}}, mon_c - MON_JAN})
              + $signed({{(TOTAL_W-STEP_W){s_months_to_add[STEP_W-1]}}, s_months_to_add});
        oor   = (total < $signed(TOTAL_W'(TOTAL_MIN))) ||
                (total > $signed(TOTAL_W'(TOTAL_MAX)));
        // divide by 12 as (total >> 2) / 3
        t17   = total[16:0];
        prod3 = 31'(t17[16:2]) * 31'(RECIP_3);
        ny    = prod3[30:17];
        ny12  = {ny, 3'b000} + 17'({ny, 2'b00});
        rem17 = t17 - ny12;
        nm    = rem17[MONTH_W-1:0] + MON_JAN;
        old_len = month_len(mon_c, leap_year(s_start_year));
    end

    logic                a_valid_reg;
    logic                a_oor_reg;
    logic [YEAR_W-1:0]   a_year_reg;
    logic [MONTH_W-1:0]  a_month_reg;
    logic [DAY_W-1:0]    a_day_reg;
    logic [DAY_W-1:0]    a_old_len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_oor_reg     <= oor;
            a_year_reg    <= ny;
            a_month_reg   <= nm;
            a_day_reg     <= s_start_day;
            a_old_len_reg <= old_len;
        end
    end

    // ---------------- stage 2: anchored day ----------------
    logic [DAY_W-1:0]   new_len;
    logic [DAY_W-1:0]   year_next_unused_day;
    logic [YEAR_W-1:0]  year_next;
    logic [MONTH_W-1:0] month_next;
    logic [DAY_W-1:0]   day_next;

    always_comb begin
        new_len = month_len(a_month_reg, leap_year(a_year_reg));
        if (a_day_reg < DAY_W'(ANCHOR_DAY)) begin
            year_next_unused_day = a_day_reg;
        end else if (a_day_reg > a_old_len_reg) begin
            // start day past its month end: saturate at new month end
            year_next_unused_day = new_len;
        end else begin
            year_next_unused_day = new_len - (a_old_len_reg - a_day_reg);
        end
        if (a_oor_reg) begin
            year_next  = '0;
            month_next = '0;
            day_next   = '0;
        end else begin
            year_next  = a_year_reg;
            month_next = a_month_reg;
            day_next   = year_next_unused_day;
        end
    end

    logic                m_valid_reg;
    logic                m_oor_reg;
    logic [YEAR_W-1:0]   m_year_reg;
    logic [MONTH_W-1:0]  m_month_reg;
    logic [DAY_W-1:0]    m_day_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_oor_reg   <= a_oor_reg;
            m_year_reg  <= year_next;
            m_month_reg <= month_next;
            m_day_reg   <= day_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_of_range = m_oor_reg;
    assign m_result_year  = m_year_reg;
    assign m_result_month = m_month_reg;
    assign m_result_day   = m_day_reg;

    // ---------------- assertions ----------------
    `ASSERT_IMPLIES(a_oor_zero, aclk, aresetn, m_valid && m_out_of_range, (m_result_year == '0) && (m_result_month == '0) && (m_result_day == '0))
    `ASSERT_IMPLIES(a_month_ok, aclk, aresetn, m_valid && !m_out_of_range, (m_result_month >= MON_JAN) && (m_result_month <= MON_DEC))
    `ASSERT_IMPLIES(a_year_ok, aclk, aresetn, m_valid && !m_out_of_range, (m_result_year >= YEAR_W'(YEAR_MIN)) && (m_result_year <= YEAR_W'(YEAR_MAX)))
    `ASSERT_NEXT(a_stage_moves, aclk, aresetn, a_valid_reg && adv, m_valid)
    `ASSERT_NEXT(a_stage_holds, aclk, aresetn, a_valid_reg && !adv, a_valid_reg)

endmodule
